// ----- rtl/core/edist_pkg.sv -----
package edist_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned SymW = 8;
  localparam int unsigned DistW = 7;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_FEED   = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_IGNORE = 2'd3
  } edist_func_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } edist_state_e;

  typedef struct packed {
    edist_func_e      func;
    logic [SymW-1:0]  symbol;
  } edist_in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             too_long;
    logic             bad_order;
  } edist_out_t;

  // Control word that moves one cell down the chain every cycle.
  typedef struct packed {
    logic            valid;
    logic            token;
    logic [SymW-1:0] sym;
  } edist_beat_t;

endpackage

// ----- rtl/core/edist_cell.sv -----
module edist_cell #(
  parameter int unsigned VW    = 7,
  parameter int unsigned INDEX = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  edist_pkg::edist_beat_t     beat_i,
  input  logic [VW-1:0]              left_i,
  input  logic [VW-1:0]              diag_i,
  input  logic                       last_i,
  input  logic                       append_i,
  input  logic [edist_pkg::SymW-1:0] app_sym_i,
  output edist_pkg::edist_beat_t     beat_o,
  output logic [VW-1:0]              left_o,
  output logic [VW-1:0]              diag_o,
  output logic                       last_o
);

  edist_pkg::edist_beat_t     beat_q, beat_d;
  logic [VW-1:0]              left_q, left_d;
  logic [VW-1:0]              diag_q, diag_d;
  logic [VW-1:0]              value_q, value_d;
  logic                       last_q, last_d;
  logic [edist_pkg::SymW-1:0] byte_q, byte_d;
  logic [VW-1:0]              min_ul, min_all, next_val;

  always_comb begin
    min_ul  = (value_q < left_i) ? value_q : left_i;
    min_all = (min_ul < diag_i) ? min_ul : diag_i;
    if (beat_i.sym == byte_q) begin
      next_val = diag_i;
    end else begin
      next_val = min_all + VW'(1);
    end

    beat_d  = beat_i;
    diag_d  = value_q;
    value_d = value_q;
    left_d  = next_val;
    last_d  = last_q;
    byte_d  = byte_q;

    if (beat_i.valid && beat_i.token) begin
      // The finish token picks up the value of the last stored position on
      // its way down and puts every cell back to its initial value.
      left_d  = last_q ? value_q : left_i;
      value_d = VW'(INDEX);
      last_d  = 1'b0;
    end else if (beat_i.valid) begin
      value_d = next_val;
    end

    if (append_i) begin
      last_d = last_i;
      if (last_i) begin
        byte_d = app_sym_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= '0;
      value_q <= VW'(INDEX);
      last_q  <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      value_q <= value_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    diag_q <= diag_d;
    byte_q <= byte_d;
  end

  assign beat_o = beat_q;
  assign left_o = left_q;
  assign diag_o = diag_q;
  assign last_o = last_q;

endmodule

// ----- rtl/core/edit_distance_engine.sv -----
// Append and feed beats are accepted one per cycle while no finish is pending;
// each feed beat moves down the cell chain one cell per cycle, so the chain
// holds up to MAX_LEN beats. A finish beat sends a token down the chain; the
// result is held as the token leaves the last cell, then goes to the output
// register when free; no input beat is taken from the finish beat until then.
// Asynchronous active-low reset empties both strings, clears both flags and
// sets every cell to its index; no clearing pass is needed.
module edit_distance_engine #(
  parameter int unsigned MAX_LEN = edist_pkg::MaxLenDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  edist_pkg::edist_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output edist_pkg::edist_out_t out_data_o
);

  localparam int unsigned VW = $clog2(MAX_LEN + 1);

  edist_pkg::edist_state_e state_q, state_d;
  edist_pkg::edist_beat_t  beat [MAX_LEN+1];
  logic [VW-1:0]           left [MAX_LEN+1];
  logic [VW-1:0]           diag [MAX_LEN+1];
  logic                    last [MAX_LEN+1];

  logic [VW-1:0] first_len_q, first_len_d;
  logic [VW-1:0] second_len_q, second_len_d;
  logic          overflow_q, overflow_d;
  logic          order_err_q, order_err_d;
  logic [1:0]    flags_q, flags_d;
  logic [VW-1:0] res_q, res_d;
  logic          out_valid_q, out_valid_d;
  edist_pkg::edist_out_t out_data_q, out_data_d;

  logic accept, append, token_out;

  assign in_ready_o = (state_q == edist_pkg::ST_RUN);
  assign accept     = in_valid_i && in_ready_o;
  assign token_out  = beat[MAX_LEN].valid && beat[MAX_LEN].token;

  // Cell zero is the empty prefix of the first string.
  assign last[0] = (first_len_q == '0);

  always_comb begin
    state_d      = state_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    overflow_d   = overflow_q;
    order_err_d  = order_err_q;
    flags_d      = flags_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    append       = 1'b0;
    beat[0]      = '0;
    beat[0].sym  = in_data_i.symbol;
    left[0]      = second_len_q + VW'(1);
    diag[0]      = second_len_q;

    unique case (state_q)
      edist_pkg::ST_RUN: begin
        if (accept) begin
          unique case (in_data_i.func)
            edist_pkg::FUNC_APPEND: begin
              if (second_len_q != '0) begin
                order_err_d = 1'b1;
              end else if (first_len_q >= VW'(MAX_LEN)) begin
                overflow_d = 1'b1;
              end else begin
                append      = 1'b1;
                first_len_d = first_len_q + VW'(1);
              end
            end
            edist_pkg::FUNC_FEED: begin
              if (second_len_q >= VW'(MAX_LEN)) begin
                overflow_d = 1'b1;
              end else begin
                beat[0].valid = 1'b1;
                second_len_d  = second_len_q + VW'(1);
              end
            end
            edist_pkg::FUNC_FINISH: begin
              // With an empty first string the token keeps this value.
              beat[0].valid = 1'b1;
              beat[0].token = 1'b1;
              left[0]       = second_len_q;
              flags_d       = {overflow_q, order_err_q};
              first_len_d   = '0;
              second_len_d  = '0;
              overflow_d    = 1'b0;
              order_err_d   = 1'b0;
              state_d       = edist_pkg::ST_DRAIN;
            end
            default: begin
            end
          endcase
        end
      end
      edist_pkg::ST_DRAIN: begin
        if (token_out) begin
          res_d   = left[MAX_LEN];
          state_d = edist_pkg::ST_HOLD;
        end
      end
      edist_pkg::ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_data_d.distance  = edist_pkg::DistW'(res_q);
          out_data_d.too_long  = flags_q[1];
          out_data_d.bad_order = flags_q[0];
          state_d              = edist_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = edist_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= edist_pkg::ST_RUN;
      first_len_q  <= '0;
      second_len_q <= '0;
      overflow_q   <= 1'b0;
      order_err_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      overflow_q   <= overflow_d;
      order_err_q  <= order_err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q    <= flags_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
    edist_cell #(
      .VW    (VW),
      .INDEX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .beat_i    (beat[i-1]),
      .left_i    (left[i-1]),
      .diag_i    (diag[i-1]),
      .last_i    (last[i-1]),
      .append_i  (append),
      .app_sym_i (in_data_i.symbol),
      .beat_o    (beat[i]),
      .left_o    (left[i]),
      .diag_o    (diag[i]),
      .last_o    (last[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_token_only_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_out |-> state_q == edist_pkg::ST_DRAIN)
    else $error("finish token left the chain outside the drain state");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_len_q <= VW'(MAX_LEN) && second_len_q <= VW'(MAX_LEN))
    else $error("string length counter beyond its limit");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.func == edist_pkg::FUNC_FINISH
    |=> first_len_q == '0 && second_len_q == '0 && !overflow_q && !order_err_q)
    else $error("finish beat did not clear the string state");

  a_hold_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == edist_pkg::ST_HOLD && !out_valid_q |=> out_valid_q)
    else $error("held result was not moved to the output register");
`endif

endmodule
